### sv/tae_pkg.sv
// ----------------------------------------------------------------------------
// tae_pkg: shared types and constants of the tilt angle estimator
// Holds the arctangent table, register indexes, the controller state type
// and the command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
package tae_pkg;

	localparam int AtanEntries = 24;
	localparam logic [0:0] RegAlpha = 1'b0;
	localparam logic [0:0] RegInterval = 1'b1;
	localparam int AccW = 32;
	localparam int VecW = 26;

	function automatic logic signed [AccW-1:0] atan_q8cdeg(input logic [4:0] i);
		logic signed [AccW-1:0] r;
		case (i)
			5'd0: r = 32'sd1152000;
			5'd1: r = 32'sd680065;
			5'd2: r = 32'sd359328;
			5'd3: r = 32'sd182400;
			5'd4: r = 32'sd91554;
			5'd5: r = 32'sd45822;
			5'd6: r = 32'sd22916;
			5'd7: r = 32'sd11459;
			5'd8: r = 32'sd5730;
			5'd9: r = 32'sd2865;
			5'd10: r = 32'sd1432;
			5'd11: r = 32'sd716;
			5'd12: r = 32'sd358;
			5'd13: r = 32'sd179;
			5'd14: r = 32'sd90;
			5'd15: r = 32'sd45;
			5'd16: r = 32'sd22;
			5'd17: r = 32'sd11;
			5'd18: r = 32'sd6;
			5'd19: r = 32'sd3;
			5'd20: r = 32'sd1;
			5'd21: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_SQRT = 10'b0000000010,
		ST_CINI = 10'b0000000100,
		ST_CORD = 10'b0000001000,
		ST_CFIN = 10'b0000010000,
		ST_SMTH = 10'b0000100000,
		ST_DINI = 10'b0001000000,
		ST_DIV = 10'b0010000000,
		ST_DFIN = 10'b0100000000,
		ST_OUT = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic load;
		logic sqrt_init;
		logic sqrt_step;
		logic cord_init;
		logic cord_roll;
		logic cord_step;
		logic cord_fin;
		logic smooth;
		logic div_init;
		logic div_step;
		logic div_fin;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic error;
		logic out_busy;
	} stat_t;

endpackage

### sv/tae_ctrl.sv
// ----------------------------------------------------------------------------
// tae_ctrl: sequencing controller
// Steps the datapath through square roots, two CORDIC runs, smoothing and
// the rate division, counting iterations of each unit.
// ----------------------------------------------------------------------------
module tae_ctrl import tae_pkg::*; #(
	parameter int CordicIterations = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam int Iter = (CordicIterations < AtanEntries) ? CordicIterations : AtanEntries;

	state_t state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic roll_q, roll_d;

	assign in_ready = (state_q == ST_IDLE) && !stat.out_busy;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		roll_d = roll_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = ST_SQRT;
					cnt_d = '0;
				end
			end
			ST_SQRT: begin
				if (stat.error) begin
					state_d = ST_OUT;
				end else begin
					if (cnt_q == 6'd0) begin
						cmd.sqrt_init = 1'b1;
					end else begin
						cmd.sqrt_step = 1'b1;
					end
					cnt_d = cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						state_d = ST_CINI;
						roll_d = 1'b0;
					end
				end
			end
			ST_CINI: begin
				cmd.cord_init = 1'b1;
				cmd.cord_roll = roll_q;
				cnt_d = '0;
				state_d = ST_CORD;
			end
			ST_CORD: begin
				cmd.cord_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(Iter - 1)) begin
					state_d = ST_CFIN;
				end
			end
			ST_CFIN: begin
				cmd.cord_fin = 1'b1;
				cmd.cord_roll = roll_q;
				if (roll_q) begin
					state_d = ST_SMTH;
				end else begin
					roll_d = 1'b1;
					state_d = ST_CINI;
				end
			end
			ST_SMTH: begin
				cmd.smooth = 1'b1;
				state_d = ST_DINI;
			end
			ST_DINI: begin
				cmd.div_init = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					state_d = ST_DFIN;
				end
			end
			ST_DFIN: begin
				cmd.div_fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			roll_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			roll_q <= roll_d;
		end
	end

endmodule

### sv/tae_dpath.sv
// ----------------------------------------------------------------------------
// tae_dpath: arithmetic datapath
// Shared square root, CORDIC vectoring unit, smoothing multiply and a
// restoring divider, with the state and the output register.
// ----------------------------------------------------------------------------
module tae_dpath import tae_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_idx,
	input  logic [9:0]         cfg_data,
	input  logic [7:0]         raw_x,
	input  logic [7:0]         raw_y,
	input  logic [7:0]         raw_z,
	input  logic [31:0]        time_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               read_error,
	output logic signed [5:0]  x_count,
	output logic signed [5:0]  y_count,
	output logic signed [5:0]  z_count,
	output logic signed [14:0] pitch_cdeg,
	output logic signed [15:0] roll_cdeg,
	output logic [13:0]        magnitude_q8,
	output logic signed [14:0] smooth_pitch_cdeg,
	output logic signed [25:0] pitch_rate
);

	logic [8:0] alpha_q;
	logic [9:0] dflt_q;
	logic seen_q;
	logic signed [15:0] last_pitch_q;
	logic signed [23:0] smooth_q;
	logic [31:0] last_time_q;

	logic signed [5:0] x_q, y_q, z_q;
	logic err_q;
	logic [31:0] time_q;

	// Two square roots share one iteration: 44-bit radicands and 22-bit roots for magnitude and hyp.
	logic [43:0] rad_q;
	logic [21:0] root_q;
	logic [43:0] mrad_q;
	logic [21:0] mroot_q;
	logic [5:0] sbit_q;

	logic signed [VecW-1:0] cx_q, cy_q;
	logic signed [AccW-1:0] ang_q;
	logic [4:0] ci_q;
	logic signed [15:0] pitch_q, roll_q;

	logic [31:0] den_q, quo_q;
	logic [31:0] num_q;
	logic [32:0] rem_q;
	logic neg_q;
	logic signed [23:0] smooth_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 9'd64;
			dflt_q <= 10'd50;
		end else if (cfg_we) begin
			if (cfg_idx == RegAlpha) alpha_q <= cfg_data[8:0];
			else dflt_q <= cfg_data;
		end
	end

	assign stat.error = err_q;
	assign stat.out_busy = out_valid && !out_ready;

	// Square root, one result bit per cycle (bit index sbit_q counts down).
	logic [43:0] y2z2, x2;
	logic [21:0] hyp_try;
	logic [43:0] hyp_sq;
	logic [21:0] mag_try;
	logic [43:0] mag_sq;
	assign y2z2 = 44'(($signed(y_q) * $signed(y_q)) + ($signed(z_q) * $signed(z_q)));
	assign x2 = 44'($signed(x_q) * $signed(x_q));
	assign hyp_try = root_q | (22'd1 << sbit_q[4:0]);
	assign hyp_sq = 44'(hyp_try) * 44'(hyp_try);
	assign mag_try = mroot_q | (22'd1 << sbit_q[4:0]);
	assign mag_sq = 44'(mag_try) * 44'(mag_try);

	logic signed [VecW-1:0] dx, dy;
	assign dx = cy_q >>> ci_q;
	assign dy = cx_q >>> ci_q;

	logic signed [AccW-1:0] cd;
	assign cd = (ang_q + 32'sd128) >>> 8;

	logic [8:0] a_sat;
	logic signed [41:0] sum;
	assign a_sat = (alpha_q > 9'd256) ? 9'd256 : alpha_q;

	logic signed [15:0] lp_eff;
	logic signed [23:0] sm_eff;
	assign lp_eff = seen_q ? last_pitch_q : pitch_q;
	assign sm_eff = seen_q ? smooth_q : 24'(pitch_q * 16'sd256);
	assign sum = 42'($signed({1'b0, a_sat}) * pitch_q) * 42'sd256
		+ 42'($signed({1'b0, 9'd256 - a_sat}) * sm_eff) + 42'sd128;
	assign smooth_new = 24'(sum >>> 8);

	logic [31:0] interval;
	assign interval = (time_q - last_time_q) != 32'd0 ? (time_q - last_time_q)
		: ((dflt_q == 10'd0) ? 32'd1 : {22'd0, dflt_q});

	logic [32:0] rem_sh;
	assign rem_sh = {rem_q[31:0], num_q[31]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= raw_x[5:0];
			y_q <= raw_y[5:0];
			z_q <= raw_z[5:0];
			err_q <= (raw_x == 8'hFF) || (raw_y == 8'hFF) || (raw_z == 8'hFF);
			time_q <= time_ms;
		end
		if (cmd.sqrt_init) begin
			rad_q <= y2z2 << 32;
			mrad_q <= (y2z2 + x2) << 16;
			root_q <= '0;
			mroot_q <= '0;
			sbit_q <= 6'd21;
		end
		if (cmd.sqrt_step) begin
			if (hyp_sq <= rad_q) root_q <= hyp_try;
			if (mag_sq <= mrad_q) mroot_q <= mag_try;
			sbit_q <= sbit_q - 6'd1;
		end
		if (cmd.cord_init) begin
			logic signed [VecW-1:0] ix, iy;
			if (cmd.cord_roll) begin
				ix = VecW'(z_q) <<< 16;
				iy = VecW'(y_q) <<< 16;
			end else begin
				ix = VecW'({1'b0, root_q});
				iy = -(VecW'(x_q) <<< 16);
			end
			ci_q <= '0;
			if (ix < 0) begin
				cx_q <= -ix;
				cy_q <= -iy;
				ang_q <= (iy >= 0) ? 32'sd4608000 : -32'sd4608000;
			end else begin
				cx_q <= ix;
				cy_q <= iy;
				ang_q <= '0;
			end
		end
		if (cmd.cord_step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				ang_q <= ang_q + atan_q8cdeg(ci_q);
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				ang_q <= ang_q - atan_q8cdeg(ci_q);
			end
			ci_q <= ci_q + 5'd1;
		end
		if (cmd.cord_fin) begin
			logic signed [15:0] lim, r;
			lim = cmd.cord_roll ? 16'sd18000 : 16'sd9000;
			if (cd > AccW'(lim)) r = lim;
			else if (cd < -AccW'(lim)) r = -lim;
			else r = 16'(cd);
			if ((x_q == 0 && cmd.cord_roll == 1'b0 && root_q == 0)
					|| (cmd.cord_roll && y_q == 0 && z_q == 0)) r = '0;
			if (cmd.cord_roll) roll_q <= r;
			else pitch_q <= r;
		end
		if (cmd.div_init) begin
			logic signed [17:0] d;
			logic [31:0] mg;
			d = 18'(pitch_q) - 18'(lp_eff);
			neg_q <= d < 0;
			mg = 32'(d < 0 ? -d : d) * 32'd1000;
			num_q <= mg;
			den_q <= interval;
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			last_pitch_q <= '0;
			smooth_q <= '0;
			last_time_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.smooth) begin
				smooth_q <= smooth_new;
				seen_q <= 1'b1;
				if (!seen_q) last_pitch_q <= pitch_q;
			end
			if (cmd.div_fin) begin
				last_pitch_q <= pitch_q;
				last_time_q <= time_q;
			end
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_fin) begin
			logic signed [23:0] sc;
			sc = 24'((smooth_q + 24'sd128) >>> 8);
			smooth_pitch_cdeg <= sc[14:0];
			pitch_rate <= neg_q ? -$signed(quo_q[25:0]) : $signed(quo_q[25:0]);
			pitch_cdeg <= pitch_q[14:0];
			roll_cdeg <= roll_q;
			magnitude_q8 <= mroot_q[13:0];
			x_count <= x_q;
			y_count <= y_q;
			z_count <= z_q;
			read_error <= 1'b0;
		end else if (cmd.emit && err_q) begin
			smooth_pitch_cdeg <= '0;
			pitch_rate <= '0;
			pitch_cdeg <= '0;
			roll_cdeg <= '0;
			magnitude_q8 <= '0;
			x_count <= '0;
			y_count <= '0;
			z_count <= '0;
			read_error <= 1'b1;
		end
	end

endmodule

### sv/tilt_angle_estimator_unit.sv
// ----------------------------------------------------------------------------
// tilt_angle_estimator_unit: pitch, roll, magnitude and pitch rate
// Top level joining the sequencing controller and the arithmetic datapath.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     raw_x raw_y raw_z time_ms
//   out      out_valid / out_ready   read_error ... pitch_rate
//   cfg      cfg_we                  cfg_idx cfg_data
//
// An item passes through the load, the square roots, two CORDIC runs, smoothing,
// the 32-step divider and the output hand-off. A read error beat goes from the
// square roots straight to the output hand-off. Reset restores the configuration,
// controller and smoothing registers and clears out_valid.
// A new beat is taken only in idle, once the previous result has left the output register.
// ----------------------------------------------------------------------------
module tilt_angle_estimator_unit import tae_pkg::*; #(
	parameter int CordicIterations = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_idx,
	input  logic [9:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         raw_x,
	input  logic [7:0]         raw_y,
	input  logic [7:0]         raw_z,
	input  logic [31:0]        time_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               read_error,
	output logic signed [5:0]  x_count,
	output logic signed [5:0]  y_count,
	output logic signed [5:0]  z_count,
	output logic signed [14:0] pitch_cdeg,
	output logic signed [15:0] roll_cdeg,
	output logic [13:0]        magnitude_q8,
	output logic signed [14:0] smooth_pitch_cdeg,
	output logic signed [25:0] pitch_rate
);

	cmd_t cmd;
	stat_t stat;

	tae_ctrl #(.CordicIterations(CordicIterations)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	tae_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.raw_x(raw_x), .raw_y(raw_y), .raw_z(raw_z), .time_ms(time_ms),
		.out_valid(out_valid), .out_ready(out_ready), .read_error(read_error),
		.x_count(x_count), .y_count(y_count), .z_count(z_count),
		.pitch_cdeg(pitch_cdeg), .roll_cdeg(roll_cdeg), .magnitude_q8(magnitude_q8),
		.smooth_pitch_cdeg(smooth_pitch_cdeg), .pitch_rate(pitch_rate)
	);

endmodule
